// ===== sv/erc_pkg.sv =====
// shared types and constants for the three-rotor letter cipher
package erc_pkg;

	localparam int ALPHA = 26;
	localparam int LW = 5;

	// table memory a: forward wiring of the three rotors, reflector, plugboard
	localparam int MEM_A_DEPTH = 5 * ALPHA;
	localparam int AW_A = $clog2(MEM_A_DEPTH);
	// table memory b: inverse wiring of the three rotors
	localparam int MEM_B_DEPTH = 3 * ALPHA;
	localparam int AW_B = $clog2(MEM_B_DEPTH);

	localparam logic [AW_A-1:0] A_FAST_BASE = AW_A'(0);
	localparam logic [AW_A-1:0] A_MID_BASE = AW_A'(ALPHA);
	localparam logic [AW_A-1:0] A_SLOW_BASE = AW_A'(2 * ALPHA);
	localparam logic [AW_A-1:0] A_REFL_BASE = AW_A'(3 * ALPHA);
	localparam logic [AW_A-1:0] A_PLUG_BASE = AW_A'(4 * ALPHA);
	localparam logic [AW_B-1:0] B_FAST_BASE = AW_B'(0);
	localparam logic [AW_B-1:0] B_MID_BASE = AW_B'(ALPHA);
	localparam logic [AW_B-1:0] B_SLOW_BASE = AW_B'(2 * ALPHA);

	// actions
	localparam logic [1:0] ACT_ENCRYPT = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// table selects
	localparam logic [2:0] TBL_FAST = 3'd0;
	localparam logic [2:0] TBL_MIDDLE = 3'd1;
	localparam logic [2:0] TBL_SLOW = 3'd2;
	localparam logic [2:0] TBL_REFL = 3'd3;
	localparam logic [2:0] TBL_PLUG = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_START_FAST = 3'd0;
	localparam logic [2:0] CFG_START_MIDDLE = 3'd1;
	localparam logic [2:0] CFG_START_SLOW = 3'd2;
	localparam logic [2:0] CFG_NOTCH_FAST = 3'd3;
	localparam logic [2:0] CFG_NOTCH_MIDDLE = 3'd4;

	// configuration reset values
	localparam logic [LW-1:0] RST_START_FAST = LW'(23);
	localparam logic [LW-1:0] RST_START_MIDDLE = LW'(3);
	localparam logic [LW-1:0] RST_START_SLOW = LW'(7);
	localparam logic [LW-1:0] RST_NOTCH_FAST = LW'(22);
	localparam logic [LW-1:0] RST_NOTCH_MIDDLE = LW'(5);

	typedef struct packed {
		logic [1:0]    action;
		logic [2:0]    table_select;
		logic [LW-1:0] entry_index;
		logic [LW-1:0] entry_value;
		logic [LW-1:0] plain_letter;
	} in_item_t;

	typedef struct packed {
		logic [LW-1:0] cipher_letter;
		logic [LW-1:0] fast_position;
		logic [LW-1:0] middle_position;
		logic [LW-1:0] slow_position;
	} out_item_t;

	// lookup sequencer; each state names the table whose read data is arriving
	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_PLUG_IN  = 10'b00_0000_0010,
		ST_FAST_FWD = 10'b00_0000_0100,
		ST_MID_FWD  = 10'b00_0000_1000,
		ST_SLOW_FWD = 10'b00_0001_0000,
		ST_REFL     = 10'b00_0010_0000,
		ST_SLOW_INV = 10'b00_0100_0000,
		ST_MID_INV  = 10'b00_1000_0000,
		ST_FAST_INV = 10'b01_0000_0000,
		ST_PLUG_OUT = 10'b10_0000_0000
	} eng_state_t;

endpackage

// ===== sv/enigma_rotor_cipher.sv =====
// three-rotor letter cipher with loadable wiring tables held in two memories
//
// input channel (item_valid/item_ready/item): each transfer is a table load,
// a restart of the rotor positions, or one letter to encipher. loads and
// restarts give no result; back-to-back loads are taken
// every cycle. a letter steps the rotors at its transfer, then runs nine
// dependent lookups through the table memories (plugboard, three rotors
// forward, reflector, three rotors inverse, plugboard), one lookup per cycle
// on the synchronous read port; the letter holds the lookup engine until
// its last lookup step hands on the result, and no new letter is taken before.
// output channel (result_valid/result_ready/result): the result register is
// loaded when the letter's last lookup step finds it free. the engine takes a new item
// while a result still waits; if the receiver stalls, a second finished
// letter waits in its last lookup step and input is held off.
// config port (cfg_write/cfg_index/cfg_data): writes start and notch
// registers at once; write only while the block is idle.
// reset clears control state, sets start/notch registers to their defaults
// and the rotors to the default start positions; the wiring tables are
// undefined until loaded.
module enigma_rotor_cipher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  erc_pkg::in_item_t item,
	output logic              result_valid,
	input  logic              result_ready,
	output erc_pkg::out_item_t result,
	input  logic              cfg_write,
	input  logic [2:0]        cfg_index,
	input  logic [erc_pkg::LW-1:0] cfg_data
);

	// (a + b) mod alphabet for a, b below the alphabet size
	function automatic logic [erc_pkg::LW-1:0] add_mod(input logic [erc_pkg::LW-1:0] a,
			input logic [erc_pkg::LW-1:0] b);
		logic [erc_pkg::LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (erc_pkg::LW+1)'(erc_pkg::ALPHA)) begin
			s = s - (erc_pkg::LW+1)'(erc_pkg::ALPHA);
		end
		return s[erc_pkg::LW-1:0];
	endfunction

	// (w - p) mod alphabet
	function automatic logic [erc_pkg::LW-1:0] sub_mod(input logic [erc_pkg::LW-1:0] w,
			input logic [erc_pkg::LW-1:0] p);
		logic [erc_pkg::LW:0] d;
		if (w >= p) begin
			d = {1'b0, w} - {1'b0, p};
		end else begin
			d = {1'b0, w} + (erc_pkg::LW+1)'(erc_pkg::ALPHA) - {1'b0, p};
		end
		return d[erc_pkg::LW-1:0];
	endfunction

	// reduce a 5-bit value once below the alphabet size
	function automatic logic [erc_pkg::LW-1:0] fold(input logic [erc_pkg::LW-1:0] v);
		logic [erc_pkg::LW-1:0] r;
		r = v;
		if (v >= erc_pkg::LW'(erc_pkg::ALPHA)) begin
			r = v - erc_pkg::LW'(erc_pkg::ALPHA);
		end
		return r;
	endfunction

	function automatic logic [erc_pkg::LW-1:0] inc_mod(input logic [erc_pkg::LW-1:0] p);
		return (p == erc_pkg::LW'(erc_pkg::ALPHA - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration registers
	logic [erc_pkg::LW-1:0] start_fast_q, start_middle_q, start_slow_q;
	logic [erc_pkg::LW-1:0] notch_fast_q, notch_middle_q;

	// rotor positions
	logic [erc_pkg::LW-1:0] pos_fast_q, pos_mid_q, pos_slow_q;
	logic [erc_pkg::LW-1:0] step_fast, step_mid, step_slow;
	logic                   middle_ready, carry_middle;
	logic [erc_pkg::LW-1:0] before_notch;

	// table memories
	logic [erc_pkg::LW-1:0]   mem_a [erc_pkg::MEM_A_DEPTH];
	logic [erc_pkg::LW-1:0]   mem_b [erc_pkg::MEM_B_DEPTH];
	logic [erc_pkg::LW-1:0]   rdata_a_q, rdata_b_q;
	logic                     re_a, re_b, we_a, we_b;
	logic [erc_pkg::AW_A-1:0] raddr_a, waddr_a;
	logic [erc_pkg::AW_B-1:0] raddr_b, waddr_b;
	logic [erc_pkg::LW-1:0]   wdata_a, wdata_b;

	// sequencer
	erc_pkg::eng_state_t    state_q, state_d;
	logic                   take, take_letter, take_load, take_restart;
	logic                   load_ok, out_free, finish;
	logic [erc_pkg::LW-1:0] cur;

	assign out_free = !result_valid || result_ready;
	// a finished letter leaves the engine once the result register is free
	assign finish = (state_q == erc_pkg::ST_PLUG_OUT) && out_free;
	assign item_ready = (state_q == erc_pkg::ST_IDLE) || finish;
	assign take = item_valid && item_ready;
	assign take_letter = take && (item.action == erc_pkg::ACT_ENCRYPT);
	assign take_load = take && (item.action == erc_pkg::ACT_LOAD);
	assign take_restart = take && (item.action == erc_pkg::ACT_RESTART);
	// loads with an index or value beyond the alphabet are dropped
	assign load_ok = (item.entry_index < erc_pkg::LW'(erc_pkg::ALPHA)) &&
		(item.entry_value < erc_pkg::LW'(erc_pkg::ALPHA));

	// rotor stepping with double step at the middle notch
	always_comb begin
		before_notch = (notch_middle_q == '0) ? erc_pkg::LW'(erc_pkg::ALPHA - 1)
			: notch_middle_q - 1'b1;
		middle_ready = (notch_middle_q < erc_pkg::LW'(erc_pkg::ALPHA)) &&
			(pos_mid_q == before_notch);
		step_fast = inc_mod(pos_fast_q);
		carry_middle = (step_fast == notch_fast_q) || middle_ready;
		step_mid = carry_middle ? inc_mod(pos_mid_q) : pos_mid_q;
		step_slow = (carry_middle && (step_mid == notch_middle_q)) ? inc_mod(pos_slow_q)
			: pos_slow_q;
	end

	// table writes for loads: forward wiring into a, inverse wiring into b
	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		waddr_a = '0;
		waddr_b = '0;
		wdata_a = item.entry_value;
		wdata_b = item.entry_index;
		if (take_load && load_ok) begin
			case (item.table_select)
				erc_pkg::TBL_FAST: begin
					we_a = 1'b1;
					we_b = 1'b1;
					waddr_a = erc_pkg::A_FAST_BASE + erc_pkg::AW_A'(item.entry_index);
					waddr_b = erc_pkg::B_FAST_BASE + erc_pkg::AW_B'(item.entry_value);
				end
				erc_pkg::TBL_MIDDLE: begin
					we_a = 1'b1;
					we_b = 1'b1;
					waddr_a = erc_pkg::A_MID_BASE + erc_pkg::AW_A'(item.entry_index);
					waddr_b = erc_pkg::B_MID_BASE + erc_pkg::AW_B'(item.entry_value);
				end
				erc_pkg::TBL_SLOW: begin
					we_a = 1'b1;
					we_b = 1'b1;
					waddr_a = erc_pkg::A_SLOW_BASE + erc_pkg::AW_A'(item.entry_index);
					waddr_b = erc_pkg::B_SLOW_BASE + erc_pkg::AW_B'(item.entry_value);
				end
				erc_pkg::TBL_REFL: begin
					we_a = 1'b1;
					waddr_a = erc_pkg::A_REFL_BASE + erc_pkg::AW_A'(item.entry_index);
				end
				erc_pkg::TBL_PLUG: begin
					we_a = 1'b1;
					waddr_a = erc_pkg::A_PLUG_BASE + erc_pkg::AW_A'(item.entry_index);
				end
				default: begin
					we_a = 1'b0;
				end
			endcase
		end
	end

	// lookup chain: strip the rotor offset from the arriving data, then
	// issue the next read with the following rotor's offset added
	always_comb begin
		re_a = 1'b0;
		re_b = 1'b0;
		raddr_a = '0;
		raddr_b = '0;
		cur = rdata_a_q;
		state_d = state_q;
		case (state_q)
			erc_pkg::ST_PLUG_IN: begin
				cur = rdata_a_q;
				re_a = 1'b1;
				raddr_a = erc_pkg::A_FAST_BASE + erc_pkg::AW_A'(add_mod(cur, pos_fast_q));
				state_d = erc_pkg::ST_FAST_FWD;
			end
			erc_pkg::ST_FAST_FWD: begin
				cur = sub_mod(rdata_a_q, pos_fast_q);
				re_a = 1'b1;
				raddr_a = erc_pkg::A_MID_BASE + erc_pkg::AW_A'(add_mod(cur, pos_mid_q));
				state_d = erc_pkg::ST_MID_FWD;
			end
			erc_pkg::ST_MID_FWD: begin
				cur = sub_mod(rdata_a_q, pos_mid_q);
				re_a = 1'b1;
				raddr_a = erc_pkg::A_SLOW_BASE + erc_pkg::AW_A'(add_mod(cur, pos_slow_q));
				state_d = erc_pkg::ST_SLOW_FWD;
			end
			erc_pkg::ST_SLOW_FWD: begin
				cur = sub_mod(rdata_a_q, pos_slow_q);
				re_a = 1'b1;
				raddr_a = erc_pkg::A_REFL_BASE + erc_pkg::AW_A'(cur);
				state_d = erc_pkg::ST_REFL;
			end
			erc_pkg::ST_REFL: begin
				cur = fold(rdata_a_q);
				re_b = 1'b1;
				raddr_b = erc_pkg::B_SLOW_BASE + erc_pkg::AW_B'(add_mod(cur, pos_slow_q));
				state_d = erc_pkg::ST_SLOW_INV;
			end
			erc_pkg::ST_SLOW_INV: begin
				cur = sub_mod(rdata_b_q, pos_slow_q);
				re_b = 1'b1;
				raddr_b = erc_pkg::B_MID_BASE + erc_pkg::AW_B'(add_mod(cur, pos_mid_q));
				state_d = erc_pkg::ST_MID_INV;
			end
			erc_pkg::ST_MID_INV: begin
				cur = sub_mod(rdata_b_q, pos_mid_q);
				re_b = 1'b1;
				raddr_b = erc_pkg::B_FAST_BASE + erc_pkg::AW_B'(add_mod(cur, pos_fast_q));
				state_d = erc_pkg::ST_FAST_INV;
			end
			erc_pkg::ST_FAST_INV: begin
				cur = sub_mod(rdata_b_q, pos_fast_q);
				re_a = 1'b1;
				raddr_a = erc_pkg::A_PLUG_BASE + erc_pkg::AW_A'(cur);
				state_d = erc_pkg::ST_PLUG_OUT;
			end
			erc_pkg::ST_PLUG_OUT: begin
				// cipher letter sits in rdata_a_q and holds while stalled
				if (finish) begin
					state_d = erc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = erc_pkg::ST_IDLE;
			end
		endcase
		// a new letter starts with the plugboard read
		if (take_letter) begin
			re_a = 1'b1;
			raddr_a = erc_pkg::A_PLUG_BASE + erc_pkg::AW_A'(fold(item.plain_letter));
			state_d = erc_pkg::ST_PLUG_IN;
		end
	end

	// table memories with registered read data; read data holds when not read
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr_a] <= wdata_a;
		end
		if (re_a) begin
			rdata_a_q <= mem_a[raddr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr_b] <= wdata_b;
		end
		if (re_b) begin
			rdata_b_q <= mem_b[raddr_b];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_fast_q <= erc_pkg::RST_START_FAST;
			start_middle_q <= erc_pkg::RST_START_MIDDLE;
			start_slow_q <= erc_pkg::RST_START_SLOW;
			notch_fast_q <= erc_pkg::RST_NOTCH_FAST;
			notch_middle_q <= erc_pkg::RST_NOTCH_MIDDLE;
		end else if (cfg_write) begin
			case (cfg_index)
				erc_pkg::CFG_START_FAST: start_fast_q <= cfg_data;
				erc_pkg::CFG_START_MIDDLE: start_middle_q <= cfg_data;
				erc_pkg::CFG_START_SLOW: start_slow_q <= cfg_data;
				erc_pkg::CFG_NOTCH_FAST: notch_fast_q <= cfg_data;
				erc_pkg::CFG_NOTCH_MIDDLE: notch_middle_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// rotor positions: step on a letter, reload on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_fast_q <= fold(erc_pkg::RST_START_FAST);
			pos_mid_q <= fold(erc_pkg::RST_START_MIDDLE);
			pos_slow_q <= fold(erc_pkg::RST_START_SLOW);
		end else if (take_letter) begin
			pos_fast_q <= step_fast;
			pos_mid_q <= step_mid;
			pos_slow_q <= step_slow;
		end else if (take_restart) begin
			pos_fast_q <= fold(start_fast_q);
			pos_mid_q <= fold(start_middle_q);
			pos_slow_q <= fold(start_slow_q);
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result register; positions are still those of the finishing letter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (finish) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result.cipher_letter <= rdata_a_q;
			result.fast_position <= pos_fast_q;
			result.middle_position <= pos_mid_q;
			result.slow_position <= pos_slow_q;
		end
	end

endmodule
